// ===== rtl/core/pie_pkg.sv =====
// pie_pkg: shared types and constants for the positional insert/erase array.
// Used by the interfaces, the cell, the cell row and the top level.
`timescale 1ns / 1ps
`default_nettype none

package pie_pkg;

   localparam int DEPTH     = 64;
   localparam int WORD_BITS = 32;

   localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(DEPTH + 1);

   localparam int ACTION_BITS   = 3;
   localparam int POSITION_BITS = 6;
   localparam int VALUE_BITS    = 32;
   localparam int COUNT_BITS    = 7;
   localparam int STATUS_BITS   = 2;

   localparam int CMP_BITS = (CNT_BITS > POSITION_BITS) ? CNT_BITS + 1 : POSITION_BITS + 1;

   typedef enum logic [ACTION_BITS-1:0] {
      ACT_APPEND = 3'd0,
      ACT_INSERT = 3'd1,
      ACT_ERASE  = 3'd2,
      ACT_READ   = 3'd3,
      ACT_WRITE  = 3'd4
   } action_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // one command broadcast to every cell of the row
   typedef struct packed {
      logic                 shift_up;
      logic                 shift_down;
      logic                 write;
      logic [IDX_BITS-1:0]  pos;
      logic [WORD_BITS-1:0] value;
   } pie_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/core/pie_if.sv =====
// pie_if: valid/ready channel interfaces for request and response words.
// Depends on pie_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface pie_req_if
   import pie_pkg::*;
   ();
   logic                            valid;
   logic                            ready;
   logic [ACTION_BITS-1:0]          action;
   logic [POSITION_BITS-1:0]        position;
   logic signed [VALUE_BITS-1:0]    value;

   modport source (output valid, output action, output position, output value, input ready);
   modport sink   (input valid, input action, input position, input value, output ready);
endinterface

interface pie_rsp_if
   import pie_pkg::*;
   ();
   logic                            valid;
   logic                            ready;
   logic signed [VALUE_BITS-1:0]    read_value;
   logic [COUNT_BITS-1:0]           entry_count;
   logic [STATUS_BITS-1:0]          status;

   modport source (output valid, output read_value, output entry_count, output status,
                   input ready);
   modport sink   (input valid, input read_value, input entry_count, input status,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/positional_insert_erase_array_core.sv =====
// positional_insert_erase_array_core: ordered list of DEPTH signed words with
// append, insert, erase, read and overwrite at a position.
// Depends on pie_pkg, pie_if and pie_row.
//
// Usage:
//   req_port carries one request word: action, position, value. It is taken
//   at a clock edge where valid and ready are both high.
//   rsp_port returns exactly one response word per request: read_value (the
//   entry for a good read, else zero), entry_count after the request, and
//   status (done, list full, position outside list). A flagged request
//   leaves the list untouched.
//   The response is registered: it is valid the cycle after the request is taken.
//   Throughput: one request per cycle while responses are taken. Every cell of the row shifts or
//   loads in the same cycle, so insert and erase cost no more than a read.
//   The response register frees itself when taken, so a new request is
//   taken in the same cycle the previous response leaves.
//   A stalled response holds; req_port.ready stays low until it is taken.
//   Reset (synchronous, active high) empties the list and drops any pending
//   response; no clearing pass is needed, entries at or above the count are
//   never read.
`timescale 1ns / 1ps
`default_nettype none

module positional_insert_erase_array_core
   import pie_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   pie_req_if.sink    req_port,
   pie_rsp_if.source  rsp_port
);

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [VALUE_BITS-1:0]  read_value_ff;
   logic [VALUE_BITS-1:0]  read_value_in;
   logic [COUNT_BITS-1:0]  entry_count_ff;
   logic [COUNT_BITS-1:0]  entry_count_in;
   status_type             status_ff;
   status_type             status_in;
   logic [CNT_BITS-1:0]    count_ff;
   logic [CNT_BITS-1:0]    count_in;

   logic                   accept;
   logic                   full;
   logic [CMP_BITS-1:0]    pos_ext;
   logic [CMP_BITS-1:0]    cnt_ext;
   logic                   pos_in_list;
   logic                   pos_le_count;
   logic                   do_read;
   logic [WORD_BITS-1:0]   read_word;
   logic [VALUE_BITS-1:0]  read_ext;
   pie_cmd_type            cmd;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept         = req_port.valid && req_port.ready;

   assign full         = (count_ff == CNT_BITS'(DEPTH));
   assign pos_ext      = CMP_BITS'(req_port.position);
   assign cnt_ext      = CMP_BITS'(count_ff);
   assign pos_in_list  = (pos_ext < cnt_ext);
   assign pos_le_count = (pos_ext <= cnt_ext);

   always_comb begin
      cmd.shift_up   = 1'b0;
      cmd.shift_down = 1'b0;
      cmd.write      = 1'b0;
      cmd.pos        = IDX_BITS'(req_port.position);
      cmd.value      = WORD_BITS'(req_port.value);
      status_in      = ST_DONE;
      count_in       = count_ff;
      do_read        = 1'b0;
      case (req_port.action)
         ACT_APPEND: begin
            if (full) begin
               status_in = ST_FULL;
            end else begin
               cmd.write = 1'b1;
               cmd.pos   = IDX_BITS'(count_ff);
               count_in  = count_ff + 1'b1;
            end
         end
         ACT_INSERT: begin
            if (full) begin
               status_in = ST_FULL;
            end else if (!pos_le_count) begin
               status_in = ST_RANGE;
            end else begin
               cmd.shift_up = 1'b1;
               count_in     = count_ff + 1'b1;
            end
         end
         ACT_ERASE: begin
            if (!pos_in_list) begin
               status_in = ST_RANGE;
            end else begin
               cmd.shift_down = 1'b1;
               count_in       = count_ff - 1'b1;
            end
         end
         ACT_READ: begin
            if (!pos_in_list) begin
               status_in = ST_RANGE;
            end else begin
               do_read = 1'b1;
            end
         end
         ACT_WRITE: begin
            if (!pos_in_list) begin
               status_in = ST_RANGE;
            end else begin
               cmd.write = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (!accept) begin
         cmd.shift_up   = 1'b0;
         cmd.shift_down = 1'b0;
         cmd.write      = 1'b0;
         count_in       = count_ff;
      end
   end

   pie_row u_row (
      .clock     (clock),
      .cmd       (cmd),
      .read_word (read_word)
   );

   if (WORD_BITS >= VALUE_BITS) begin : g_rd_trunc
      assign read_ext = read_word[VALUE_BITS-1:0];
   end else begin : g_rd_sext
      assign read_ext = {{(VALUE_BITS-WORD_BITS){read_word[WORD_BITS-1]}}, read_word};
   end

   assign read_value_in  = do_read ? read_ext : '0;
   assign entry_count_in = COUNT_BITS'(count_in);
   assign rsp_valid_in   = accept || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_value_ff  <= read_value_in;
         entry_count_ff <= entry_count_in;
         status_ff      <= status_in;
      end
   end

   assign rsp_port.valid       = rsp_valid_ff;
   assign rsp_port.read_value  = read_value_ff;
   assign rsp_port.entry_count = entry_count_ff;
   assign rsp_port.status      = status_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("count above depth");

   a_flag_no_change: assert property (@(posedge clock) disable iff (reset)
      (accept && status_in != ST_DONE) |=> count_ff == $past(count_ff))
      else $error("flagged word changed count");

   a_idle_no_change: assert property (@(posedge clock) disable iff (reset)
      !accept |=> count_ff == $past(count_ff))
      else $error("count changed without a word");

   a_flag_zero_read: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_DONE) |-> read_value_ff == '0)
      else $error("flagged word returned data");

endmodule

`default_nettype wire

// ===== rtl/core/pie_cell.sv =====
// pie_cell: one list slot; holds a word and takes it from a neighbor on shifts.
// Depends on pie_pkg for the command struct.
`timescale 1ns / 1ps
`default_nettype none

module pie_cell
   import pie_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [IDX_BITS-1:0]  cell_index,
   input  wire pie_cmd_type          cmd,
   input  wire logic [WORD_BITS-1:0] left_word,
   input  wire logic [WORD_BITS-1:0] right_word,
   output logic [WORD_BITS-1:0]      word_out,
   output logic [WORD_BITS-1:0]      hit_word
);

   logic [WORD_BITS-1:0] word_ff;
   logic [WORD_BITS-1:0] word_in;
   logic                 at_pos;
   logic                 above_pos;

   assign at_pos    = (cell_index == cmd.pos);
   assign above_pos = (cell_index > cmd.pos);

   always_comb begin
      word_in = word_ff;
      if (cmd.shift_up) begin
         if (above_pos) begin
            word_in = left_word;
         end else if (at_pos) begin
            word_in = cmd.value;
         end
      end else if (cmd.shift_down) begin
         if (above_pos || at_pos) begin
            word_in = right_word;
         end
      end else if (cmd.write && at_pos) begin
         word_in = cmd.value;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;
   assign hit_word = word_ff & {WORD_BITS{at_pos}};

endmodule

`default_nettype wire

// ===== rtl/core/pie_row.sv =====
// pie_row: chain of DEPTH cells with neighbor links and a read-out OR tree.
// Depends on pie_pkg and pie_cell.
`timescale 1ns / 1ps
`default_nettype none

module pie_row
   import pie_pkg::*;
(
   input  wire logic            clock,
   input  wire pie_cmd_type     cmd,
   output logic [WORD_BITS-1:0] read_word
);

   logic [WORD_BITS-1:0] cell_word [DEPTH];
   logic [WORD_BITS-1:0] cell_hit  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [WORD_BITS-1:0] left_w;
      logic [WORD_BITS-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_mid_l
         assign left_w = cell_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_mid_r
         assign right_w = cell_word[i+1];
      end

      pie_cell u_cell (
         .clock      (clock),
         .cell_index (IDX_BITS'(i)),
         .cmd        (cmd),
         .left_word  (left_w),
         .right_word (right_w),
         .word_out   (cell_word[i]),
         .hit_word   (cell_hit[i])
      );
   end

   always_comb begin
      read_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_word = read_word | cell_hit[i];
      end
   end

endmodule

`default_nettype wire
